// ----- hdl/cfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cfa_pkg;

    // pool size default
    localparam int NFRAMES_DEFAULT = 1024;

    // field widths
    localparam int FRAME_W = 20;
    localparam int COUNT_W = 11;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 3;
    localparam int FS_W    = 2;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MARK    = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NOSPACE  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_BADRANGE = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOTHEAD  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_INUSE    = 3'd4;

    // per-frame state encoding
    localparam logic [FS_W-1:0] FS_FREE = 2'd0;
    localparam logic [FS_W-1:0] FS_HEAD = 2'd1;
    localparam logic [FS_W-1:0] FS_USED = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FRAME_W-1:0] frame_no;
        logic [COUNT_W-1:0] count;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FRAME_W-1:0] first_frame;
        logic [COUNT_W-1:0] free_frames;
    } out_item_t;

endpackage

`default_nettype wire

// ----- hdl/contiguous_frame_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// throughput: one request at a time; the frame state memory is walked one entry per cycle
// reset: rst_n clears control, then a clearing pass writes every frame free, during which no
//   request is taken (base_frame writes are taken as ever)
module contiguous_frame_allocator #(
    parameter int NFRAMES = cfa_pkg::NFRAMES_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration
    input  wire logic                             cfg_we,
    input  wire logic [cfa_pkg::FRAME_W-1:0]      cfg_wdata,
    // request beats
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire cfa_pkg::in_item_t                in_data,
    // result beats
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output cfa_pkg::out_item_t                    out_data
);

    localparam int AW = $clog2(NFRAMES);        // frame index width
    localparam int CW = $clog2(NFRAMES + 1);    // frame count width
    localparam int FW = cfa_pkg::FRAME_W;
    localparam int OW = cfa_pkg::COUNT_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(NFRAMES - 1);

    // one-hot controller states
    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,   // post-reset sweep writing every frame free
        S_IDLE  = 7'b0000010,   // waiting for a request beat
        S_SCAN  = 7'b0000100,   // first-fit scan or mark range check
        S_RCHK  = 7'b0001000,   // release: head check on the first frame
        S_RWALK = 7'b0010000,   // release: free the trailing allocated frames
        S_CLAIM = 7'b0100000,   // write head then allocated frames
        S_DONE  = 7'b1000000    // hand result to the output register
    } state_t;

    state_t                        state_reg, state_next;
    logic [AW-1:0]                 idx_reg, idx_next;
    logic [CW-1:0]                 run_reg, run_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [CW-1:0]                 rem_reg, rem_next;
    logic [AW-1:0]                 start_reg, start_next;
    logic [cfa_pkg::KIND_W-1:0]    kind_reg, kind_next;
    logic [cfa_pkg::STAT_W-1:0]    status_reg, status_next;
    logic [FW-1:0]                 first_reg, first_next;
    logic [CW-1:0]                 free_count_reg, free_count_next;
    logic [FW-1:0]                 base_frame_reg;
    logic                          out_valid_reg, out_valid_next;
    cfa_pkg::out_item_t            out_data_reg, out_data_next;

    // frame state memory port signals
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [cfa_pkg::FS_W-1:0]      mem_wdata;
    logic [AW-1:0]                 mem_raddr;
    logic [cfa_pkg::FS_W-1:0]      mem_rdata;

    // request decode
    logic                          below_base;
    logic [FW-1:0]                 rel_idx;
    logic                          idx_outside;
    logic                          cnt_zero;
    logic [CW-1:0]                 run_plus;

    cfa_ram #(
        .WIDTH (cfa_pkg::FS_W),
        .DEPTH (NFRAMES)
    ) u_frame_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign below_base  = (in_data.frame_no < base_frame_reg);
    assign rel_idx     = in_data.frame_no - base_frame_reg;
    assign idx_outside = below_base || (32'(rel_idx) >= 32'(NFRAMES));
    assign cnt_zero    = (in_data.count == '0);
    assign run_plus    = run_reg + CW'(1);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        run_next        = run_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        start_next      = start_reg;
        kind_next       = kind_reg;
        status_next     = status_reg;
        first_next      = first_reg;
        free_count_next = free_count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = cfa_pkg::FS_FREE;
        // streaming read: the entry after the one whose data arrives now
        mem_raddr       = idx_reg + AW'(1);

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                mem_raddr = (in_data.kind == cfa_pkg::KIND_ALLOC) ? '0 : AW'(rel_idx);
                if (in_valid)
                begin
                    kind_next   = in_data.kind;
                    first_next  = '0;
                    run_next    = '0;
                    cnt_next    = CW'(in_data.count);
                    status_next = cfa_pkg::STAT_BADRANGE;
                    state_next  = S_DONE;
                    unique case (in_data.kind)
                        cfa_pkg::KIND_ALLOC:
                        begin
                            if (cnt_zero || 32'(in_data.count) > 32'(NFRAMES))
                            begin
                                status_next = cfa_pkg::STAT_BADRANGE;
                            end
                            else if (32'(in_data.count) > 32'(free_count_reg))
                            begin
                                status_next = cfa_pkg::STAT_NOSPACE;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        cfa_pkg::KIND_RELEASE:
                        begin
                            if (!idx_outside)
                            begin
                                idx_next   = AW'(rel_idx);
                                state_next = S_RCHK;
                            end
                        end
                        cfa_pkg::KIND_MARK:
                        begin
                            if (!(cnt_zero || idx_outside ||
                                  32'(in_data.count) > 32'(NFRAMES) - 32'(rel_idx)))
                            begin
                                idx_next   = AW'(rel_idx);
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = cfa_pkg::STAT_BADRANGE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (mem_rdata == cfa_pkg::FS_FREE)
                begin
                    if (run_plus == cnt_reg)
                    begin
                        // run complete: claim it from its first frame
                        start_next = idx_reg - AW'(cnt_reg) + AW'(1);
                        idx_next   = idx_reg - AW'(cnt_reg) + AW'(1);
                        rem_next   = cnt_reg;
                        state_next = S_CLAIM;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        status_next = cfa_pkg::STAT_NOSPACE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        run_next = run_plus;
                        idx_next = idx_reg + AW'(1);
                    end
                end
                else if (kind_reg == cfa_pkg::KIND_MARK)
                begin
                    status_next = cfa_pkg::STAT_INUSE;
                    state_next  = S_DONE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    status_next = cfa_pkg::STAT_NOSPACE;
                    state_next  = S_DONE;
                end
                else
                begin
                    run_next = '0;
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_RCHK:
            begin
                if (mem_rdata != cfa_pkg::FS_HEAD)
                begin
                    status_next = cfa_pkg::STAT_NOTHEAD;
                    state_next  = S_DONE;
                end
                else
                begin
                    mem_we          = 1'b1;
                    free_count_next = free_count_reg + CW'(1);
                    status_next     = cfa_pkg::STAT_OK;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_RWALK;
                    end
                end
            end

            S_RWALK:
            begin
                if (mem_rdata == cfa_pkg::FS_USED)
                begin
                    mem_we          = 1'b1;
                    free_count_next = free_count_reg + CW'(1);
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_CLAIM:
            begin
                mem_we    = 1'b1;
                mem_wdata = (idx_reg == start_reg) ? cfa_pkg::FS_HEAD : cfa_pkg::FS_USED;
                if (rem_reg == CW'(1))
                begin
                    free_count_next = free_count_reg - cnt_reg;
                    status_next     = cfa_pkg::STAT_OK;
                    if (kind_reg == cfa_pkg::KIND_ALLOC)
                    begin
                        first_next = base_frame_reg + FW'(start_reg);
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    rem_next = rem_reg - CW'(1);
                end
            end

            S_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.status      = status_reg;
                    out_data_next.first_frame = first_reg;
                    out_data_next.free_frames = OW'(free_count_reg);
                    out_valid_next            = 1'b1;
                    state_next                = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            free_count_reg <= CW'(NFRAMES);
            base_frame_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            free_count_reg <= free_count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                base_frame_reg <= cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        run_reg      <= run_next;
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        start_reg    <= start_next;
        kind_reg     <= kind_next;
        status_reg   <= status_next;
        first_reg    <= first_next;
        out_data_reg <= out_data_next;
    end

    // free count never exceeds the pool
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(free_count_reg) <= 32'(NFRAMES))
        else $error("free count above pool size");

    // a claim stays inside the pool
    a_claim_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLAIM) |-> (rem_reg != '0) &&
            (32'(idx_reg) + 32'(rem_reg) <= 32'(NFRAMES)))
        else $error("claim runs past the pool");

    // the current run is always shorter than the requested count while scanning
    a_run_short: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (run_reg < cnt_reg))
        else $error("scan run reached count without claiming");

    // free count only moves while releasing or claiming
    a_free_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_RCHK && state_reg != S_RWALK && state_reg != S_CLAIM)
            |=> $stable(free_count_reg))
        else $error("free count changed outside release or claim");

endmodule

`default_nettype wire

// ----- hdl/cfa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
